// ----- rtl/ucu_pkg.sv -----
// shared types and constants of the upwind advection cell update
// fixed field widths, register codes, stage payload structs
// no dependencies
package ucu_pkg;

    localparam int SAMPLE_W  = 32;   // q16.16 sample
    localparam int COURANT_W = 18;   // signed q1.16 courant number
    localparam int BASE_W    = 33;   // difference of two samples
    localparam int SDIFF_W   = 34;   // difference of two differences
    localparam int MPROD_W   = 52;   // weight times slope difference
    localparam int SCALED_W  = 53;   // interface difference at scale 2^18
    localparam int DQ_W      = 35;   // interface difference at q16.16
    localparam int CPROD_W   = 53;   // courant times interface difference
    localparam int PROD_W    = 37;   // rounded flux term at q16.16
    localparam int RES_W     = 38;   // unclamped result
    localparam int CFG_IDX_W = 2;
    localparam int NUM_STAGES = 5;

    localparam logic [CFG_IDX_W-1:0] REG_COURANT_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COURANT_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_MODE = 2'd2;

    localparam logic signed [COURANT_W:0]  Q_ONE    = 19'sd65536;
    localparam logic signed [SCALED_W-1:0] RND_DIFF = 53'sd131072;
    localparam logic signed [CPROD_W-1:0]  RND_PROD = 53'sd32768;

    localparam logic SLOPE_CONST  = 1'b0;
    localparam logic SLOPE_CENTRE = 1'b1;

    typedef struct packed {
        logic signed [COURANT_W-1:0] courant_x;
        logic signed [COURANT_W-1:0] courant_y;
        logic                        slope_mode;
    } cfg_t;

    // first stage: upwind differences and slope weight
    typedef struct packed {
        logic signed [BASE_W-1:0]    base;
        logic signed [SDIFF_W-1:0]   sdiff;
        logic signed [COURANT_W-1:0] weight;
        logic signed [COURANT_W-1:0] courant;
        logic signed [SAMPLE_W-1:0]  centre;
    } diff_t;

    // third stage: rounded interface difference
    typedef struct packed {
        logic signed [DQ_W-1:0]      dq;
        logic signed [COURANT_W-1:0] courant;
        logic signed [SAMPLE_W-1:0]  centre;
    } flux_t;

endpackage

// ----- rtl/ucu_diff.sv -----
// first pipeline stage: courant select, upwind differences, slope weight
// depends on ucu_pkg
module ucu_diff
    import ucu_pkg::*;
(
    input  logic                       clk,
    input  logic                       ld,
    input  cfg_t                       cfg,
    input  logic                       func,
    input  logic signed [SAMPLE_W-1:0] cell_m2,
    input  logic signed [SAMPLE_W-1:0] cell_m1,
    input  logic signed [SAMPLE_W-1:0] cell_center,
    input  logic signed [SAMPLE_W-1:0] cell_p1,
    input  logic signed [SAMPLE_W-1:0] cell_p2,
    output diff_t                      stage
);

    diff_t                       stage_reg;
    diff_t                       stage_next;
    logic signed [COURANT_W-1:0] c;
    logic                        pos;
    logic signed [BASE_W-1:0]    a, b, s, p, q;
    logic signed [BASE_W-1:0]    d_sb, d_ps, d_pb, d_sa, d_qs;
    logic signed [SDIFF_W-1:0]   slope_pos, slope_neg, slope;
    logic signed [COURANT_W:0]   w_pos, w_neg;

    always_comb
    begin
        c   = func ? cfg.courant_y : cfg.courant_x;
        pos = !c[COURANT_W-1] && (c != '0);
        a = {cell_m2[SAMPLE_W-1], cell_m2};
        b = {cell_m1[SAMPLE_W-1], cell_m1};
        s = {cell_center[SAMPLE_W-1], cell_center};
        p = {cell_p1[SAMPLE_W-1], cell_p1};
        q = {cell_p2[SAMPLE_W-1], cell_p2};
        d_sb = s - b;
        d_ps = p - s;
        d_pb = p - b;
        d_sa = s - a;
        d_qs = q - s;
        slope_pos = {d_pb[BASE_W-1], d_pb} - {d_sa[BASE_W-1], d_sa};
        slope_neg = {d_qs[BASE_W-1], d_qs} - {d_pb[BASE_W-1], d_pb};
        slope = pos ? slope_pos : slope_neg;
        // minus sign of the downwind branch folded into the weight
        w_pos = Q_ONE - {c[COURANT_W-1], c};
        w_neg = -Q_ONE - {c[COURANT_W-1], c};
        stage_next.base    = pos ? d_sb : d_ps;
        stage_next.sdiff   = (cfg.slope_mode == SLOPE_CENTRE) ? slope : '0;
        stage_next.weight  = pos ? w_pos[COURANT_W-1:0] : w_neg[COURANT_W-1:0];
        stage_next.courant = c;
        stage_next.centre  = cell_center;
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

// ----- rtl/ucu_flux.sv -----
// second and third pipeline stages: slope product, interface difference rounding
// depends on ucu_pkg
module ucu_flux
    import ucu_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] ld,
    input  diff_t      din,
    output flux_t      dout
);

    logic signed [MPROD_W-1:0]   mprod_reg, mprod_next;
    logic signed [BASE_W-1:0]    base_reg;
    logic signed [COURANT_W-1:0] courant_reg;
    logic signed [SAMPLE_W-1:0]  centre_reg;
    logic signed [SCALED_W-1:0]  scaled;
    flux_t                       flux_reg, flux_next;

    always_comb
    begin
        mprod_next = din.sdiff * din.weight;
    end

    always_comb
    begin
        scaled = {{2{base_reg[BASE_W-1]}}, base_reg, 18'd0}
               + {mprod_reg[MPROD_W-1], mprod_reg} + RND_DIFF;
        flux_next.dq      = scaled[SCALED_W-1:18];
        flux_next.courant = courant_reg;
        flux_next.centre  = centre_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            mprod_reg   <= mprod_next;
            base_reg    <= din.base;
            courant_reg <= din.courant;
            centre_reg  <= din.centre;
        end
        if (ld[1])
        begin
            flux_reg <= flux_next;
        end
    end

    assign dout = flux_reg;

endmodule

// ----- rtl/ucu_scale.sv -----
// fourth and fifth pipeline stages: courant product, rounding, clamp
// depends on ucu_pkg
module ucu_scale
    import ucu_pkg::*;
(
    input  logic                       clk,
    input  logic [1:0]                 ld,
    input  flux_t                      din,
    output logic signed [SAMPLE_W-1:0] new_value,
    output logic                       saturated
);

    logic signed [CPROD_W-1:0]  cprod_reg, cprod_next;
    logic signed [SAMPLE_W-1:0] centre_reg;
    logic signed [CPROD_W-1:0]  cprod_rnd;
    logic signed [PROD_W-1:0]   prod;
    logic signed [RES_W-1:0]    res;
    logic                       over_hi, over_lo;
    logic signed [SAMPLE_W-1:0] value_reg, value_next;
    logic                       sat_reg, sat_next;

    always_comb
    begin
        cprod_next = din.dq * din.courant;
    end

    always_comb
    begin
        cprod_rnd = cprod_reg + RND_PROD;
        prod      = cprod_rnd[CPROD_W-1:16];
        res       = {{(RES_W-SAMPLE_W){centre_reg[SAMPLE_W-1]}}, centre_reg}
                  - {prod[PROD_W-1], prod};
        over_hi   = !res[RES_W-1] && (res[RES_W-2:SAMPLE_W-1] != '0);
        over_lo   = res[RES_W-1] && !(&res[RES_W-2:SAMPLE_W-1]);
        sat_next  = over_hi || over_lo;
        if (over_hi)
        begin
            value_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (over_lo)
        begin
            value_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            value_next = res[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            cprod_reg  <= cprod_next;
            centre_reg <= din.centre;
        end
        if (ld[1])
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign new_value = value_reg;
    assign saturated = sat_reg;

endmodule

// ----- rtl/upwind_advection_cell_update.sv -----
// top level of the upwind advection cell update: stream ports, config registers,
// valid and ready control of the five-stage pipeline
// depends on ucu_pkg, ucu_diff, ucu_flux, ucu_scale
//
// usage
//   input stream: one transfer per cell, five neighbouring q16.16 samples along
//   the sweep in s_tdata and the sweep direction in s_tuser
//   output stream: one transfer per input, the updated q16.16 cell value in
//   m_tdata and the clip flag in m_tuser, in input order
//   config: courant_x, courant_y and slope_mode written through cfg_we,
//   cfg_index and cfg_data while the pipeline is empty; unknown index ignored
//   throughput: one cell per cycle unless m_tready stalls the output, through
//   the five register stages (differences, slope product, interface rounding,
//   courant product, clamp)
//   reset: pipeline emptied, all config registers zero
//   stall: when m_tready is low the stages fill up behind the output register;
//   s_tready only drops once every stage holds a cell, nothing is dropped
module upwind_advection_cell_update
    import ucu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // config write port
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COURANT_W-1:0]      cfg_data,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [5*SAMPLE_W-1:0]     s_tdata,  // cell_m2, cell_m1, cell_center, cell_p1, cell_p2
    input  logic                      s_tuser,  // func
    // output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [SAMPLE_W-1:0]       m_tdata,  // new_value
    output logic                      m_tuser   // saturated
);

    cfg_t                    cfg_reg;
    logic [NUM_STAGES-1:0]   valid_reg;
    logic [NUM_STAGES:0]     ready;
    logic [NUM_STAGES-1:0]   ld;
    diff_t                   diff_stage;
    flux_t                   flux_stage;
    logic signed [SAMPLE_W-1:0] new_value;
    logic                    saturated;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COURANT_X:  cfg_reg.courant_x  <= cfg_data;
                REG_COURANT_Y:  cfg_reg.courant_y  <= cfg_data;
                REG_SLOPE_MODE: cfg_reg.slope_mode <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // a stage takes new data when it is empty or its content moves on
    always_comb
    begin
        ready[NUM_STAGES] = m_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        ld[0] = ready[0] && s_tvalid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            ld[i] = ready[i] && valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    ucu_diff u_diff (
        .clk         (clk),
        .ld          (ld[0]),
        .cfg         (cfg_reg),
        .func        (s_tuser),
        .cell_m2     (s_tdata[SAMPLE_W-1:0]),
        .cell_m1     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .cell_center (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .cell_p1     (s_tdata[4*SAMPLE_W-1:3*SAMPLE_W]),
        .cell_p2     (s_tdata[5*SAMPLE_W-1:4*SAMPLE_W]),
        .stage       (diff_stage)
    );

    ucu_flux u_flux (
        .clk  (clk),
        .ld   (ld[2:1]),
        .din  (diff_stage),
        .dout (flux_stage)
    );

    ucu_scale u_scale (
        .clk       (clk),
        .ld        (ld[4:3]),
        .din       (flux_stage),
        .new_value (new_value),
        .saturated (saturated)
    );

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = new_value;
    assign m_tuser  = saturated;

    // a clipped result sits at one of the two range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == 32'h7fffffff || m_tdata == 32'h80000000))
        else $error("saturated result not at a range limit");

    // an empty output register means the whole pipeline can move
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // input held back only with every stage full and the output stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg) && !m_tready)
        else $error("input stalled with room in the pipeline");

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench of the upwind advection cell update
// drives cell stencils on the input stream, predicts each updated value and clip flag
// depends on ucu_pkg and upwind_advection_cell_update
module tb;
    import ucu_pkg::*;

    // how a stimulus row is checked
    localparam logic BY_MODEL = 1'b0;   // expected result worked out by the predictor
    localparam logic BY_HAND  = 1'b1;   // expected result typed into the row

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // courant numbers, signed q1.16
    localparam logic signed [COURANT_W-1:0] C_ZERO     = 18'sh00000;
    localparam logic signed [COURANT_W-1:0] C_ONE      = 18'sh10000;   // +1.0
    localparam logic signed [COURANT_W-1:0] C_NEG_ONE  = 18'sh30000;   // -1.0
    localparam logic signed [COURANT_W-1:0] C_HALF     = 18'sh08000;   // +0.5
    localparam logic signed [COURANT_W-1:0] C_NEG_HALF = 18'sh38000;   // -0.5
    localparam logic signed [COURANT_W-1:0] C_MAX      = 18'sh1FFFF;   // just under +2.0
    localparam logic signed [COURANT_W-1:0] C_MIN      = 18'sh20000;   // -2.0
    localparam logic signed [COURANT_W-1:0] C_LSB      = 18'sh00001;
    localparam logic signed [COURANT_W-1:0] C_NEG_LSB  = 18'sh3FFFF;

    // sample extremes, q16.16
    localparam logic signed [SAMPLE_W-1:0] S_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN  = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] S_ZERO = 32'sh0000_0000;

    localparam int STALL_MAX  = 15;
    localparam int DRAIN_WAIT = NUM_STAGES + 3;
    localparam int IDLE_LIMIT = 2000;    // cycles without any transfer or register write
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 125;

    // one input item: sweep direction and the five samples along the sweep
    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] m2;
        logic signed [SAMPLE_W-1:0] m1;
        logic signed [SAMPLE_W-1:0] ctr;
        logic signed [SAMPLE_W-1:0] p1;
        logic signed [SAMPLE_W-1:0] p2;
    } sweep_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       sat;
    } sweep_out_t;

    typedef struct packed {
        logic signed [COURANT_W-1:0] cx;
        logic signed [COURANT_W-1:0] cy;
        logic                        mode;
        sweep_in_t                   stencil;
        logic                        source;
        sweep_out_t                  want;
    } stim_row_t;

    localparam sweep_out_t FROM_MODEL = '0;
    localparam int NUM_ROWS = 24;

    // directed rows: config registers, stencil, and a typed-in result where it is obvious
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        // registers straight out of reset: zero courant number passes the centre through
        '{C_ZERO, C_ZERO, SLOPE_CONST, '{1'b0, 32'sh0001_0000, 32'sh0002_8000,
            32'sh0003_4000, 32'shFFFF_0000, 32'sh0000_0001}, BY_HAND, '{32'sh0003_4000, 1'b0}},
        '{C_ZERO, C_ZERO, SLOPE_CONST, '{1'b1, S_MIN, S_MIN, S_MAX, S_MIN, S_MIN},
            BY_HAND, '{S_MAX, 1'b0}},
        '{C_ZERO, C_ZERO, SLOPE_CONST, '{1'b0, S_MAX, S_MAX, S_MIN, S_MAX, S_MAX},
            BY_HAND, '{S_MIN, 1'b0}},
        // courant +1 along x: the update lands exactly on the upstream sample; zero courant along y keeps the centre
        '{C_ONE, C_ZERO, SLOPE_CONST, '{1'b0, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX},
            BY_HAND, '{S_MIN, 1'b0}},
        '{C_ONE, C_ZERO, SLOPE_CONST, '{1'b1, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX},
            BY_HAND, '{S_MAX, 1'b0}},
        '{C_ONE, C_ZERO, SLOPE_CONST, '{1'b0, 32'sh0000_1234, 32'shFFFE_8000,
            32'sh0004_0000, 32'sh0001_0000, S_ZERO}, BY_HAND, '{32'shFFFE_8000, 1'b0}},
        // courant -2 along x: 2*p1 - centre, clipping at both ends; y rows run just under +2
        '{C_MIN, C_MAX, SLOPE_CONST, '{1'b0, S_ZERO, S_ZERO, S_ZERO, S_MAX, S_ZERO},
            BY_HAND, '{S_MAX, 1'b1}},
        '{C_MIN, C_MAX, SLOPE_CONST, '{1'b0, S_ZERO, S_ZERO, S_ZERO, S_MIN, S_ZERO},
            BY_HAND, '{S_MIN, 1'b1}},
        '{C_MIN, C_MAX, SLOPE_CONST, '{1'b0, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN},
            BY_HAND, '{S_MAX, 1'b1}},
        '{C_MIN, C_MAX, SLOPE_CONST, '{1'b1, S_MAX, S_MIN, S_MIN, S_MAX, S_MIN},
            BY_MODEL, FROM_MODEL},
        '{C_MIN, C_MAX, SLOPE_CONST, '{1'b1, 32'sh0010_0000, 32'sh0008_0000,
            32'sh0004_0000, 32'sh0002_0000, 32'sh0001_0000}, BY_MODEL, FROM_MODEL},
        // centred slope with courant magnitude one: slope weight vanishes
        '{C_NEG_ONE, C_ONE, SLOPE_CENTRE, '{1'b0, 32'sh0005_0000, 32'shFFF0_0000,
            32'sh0002_0000, 32'sh7FFF_0000, S_MIN}, BY_HAND, '{32'sh7FFF_0000, 1'b0}},
        '{C_NEG_ONE, C_ONE, SLOPE_CENTRE, '{1'b1, 32'sh0005_0000, 32'shFFF0_0000,
            32'sh0002_0000, 32'sh7FFF_0000, S_MIN}, BY_HAND, '{32'shFFF0_0000, 1'b0}},
        '{C_NEG_ONE, C_ONE, SLOPE_CENTRE, '{1'b0, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN},
            BY_MODEL, FROM_MODEL},
        // centred slope, half courant in both directions
        '{C_HALF, C_NEG_HALF, SLOPE_CENTRE, '{1'b0, 32'sh0001_0000, 32'sh0002_0000,
            32'sh0004_0000, 32'sh0003_0000, 32'sh0001_8000}, BY_MODEL, FROM_MODEL},
        '{C_HALF, C_NEG_HALF, SLOPE_CENTRE, '{1'b1, 32'sh0001_0000, 32'sh0002_0000,
            32'sh0004_0000, 32'sh0003_0000, 32'sh0001_8000}, BY_MODEL, FROM_MODEL},
        '{C_HALF, C_NEG_HALF, SLOPE_CENTRE, '{1'b0, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX},
            BY_MODEL, FROM_MODEL},
        '{C_HALF, C_NEG_HALF, SLOPE_CENTRE, '{1'b1, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN},
            BY_MODEL, FROM_MODEL},
        // courant beyond one at both register extremes, with the slope term in play
        '{C_MAX, C_MIN, SLOPE_CENTRE, '{1'b0, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN},
            BY_MODEL, FROM_MODEL},
        '{C_MAX, C_MIN, SLOPE_CENTRE, '{1'b1, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX},
            BY_MODEL, FROM_MODEL},
        '{C_MAX, C_MIN, SLOPE_CENTRE, '{1'b0, 32'shFFFF_FFFF, 32'sh0000_0001,
            32'shFFFF_FFFE, 32'sh0000_0003, 32'shFFFF_FFFC}, BY_MODEL, FROM_MODEL},
        // smallest non-zero courant numbers, rounding of the flux term
        '{C_LSB, C_NEG_LSB, SLOPE_CONST, '{1'b0, 32'sh1234_5678, 32'sh8765_4321,
            32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh5555_5555}, BY_MODEL, FROM_MODEL},
        '{C_LSB, C_NEG_LSB, SLOPE_CONST, '{1'b1, 32'shAAAA_AAAA, 32'sh5555_5555,
            32'shCCCC_CCCC, 32'sh3333_3333, 32'shFFFF_0001}, BY_MODEL, FROM_MODEL},
        '{C_LSB, C_NEG_LSB, SLOPE_CONST, '{1'b0, S_ZERO, 32'sh0000_0100,
            32'sh0000_0200, S_ZERO, S_ZERO}, BY_HAND, '{32'sh0000_0200, 1'b0}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COURANT_W-1:0]  cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [5*SAMPLE_W-1:0] s_tdata;   // cell_m2, cell_m1, cell_center, cell_p1, cell_p2
    logic                  s_tuser;   // func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SAMPLE_W-1:0]   m_tdata;   // new_value
    logic                  m_tuser;   // saturated

    // testbench copy of the config registers, follows every write
    logic signed [COURANT_W-1:0] cur_cx;
    logic signed [COURANT_W-1:0] cur_cy;
    logic                        cur_mode;

    sweep_out_t pending_cells[$];   // updated values still owed by the block, oldest first
    int         mismatches = 0;
    int         idle_cycles = 0;
    bit         steady = 1'b0;      // both sides stream without gaps while set

    upwind_advection_cell_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    // updated centre value for one stencil under the current registers
    // interface difference kept exact at scale 2^18, then rounded half up twice
    function automatic sweep_out_t advect_stencil(input sweep_in_t st);
        longint     c;
        longint     a;
        longint     b;
        longint     s;
        longint     p;
        longint     q;
        longint     scaled;
        longint     dq;
        longint     prod;
        longint     r;
        sweep_out_t res;
        c = st.func ? longint'(cur_cy) : longint'(cur_cx);
        a = longint'(st.m2);
        b = longint'(st.m1);
        s = longint'(st.ctr);
        p = longint'(st.p1);
        q = longint'(st.p2);
        if (c > 0)
        begin
            // flow in the positive direction: upwind side is the cell behind
            scaled = (s - b) <<< 18;
            if (cur_mode == SLOPE_CENTRE)
                scaled += (longint'(Q_ONE) - c) * ((p - b) - (s - a));
        end
        else
        begin
            // zero or negative courant: upwind side is the cell ahead
            scaled = (p - s) <<< 18;
            if (cur_mode == SLOPE_CENTRE)
                scaled -= (longint'(Q_ONE) + c) * ((q - s) - (p - b));
        end
        dq   = (scaled + longint'(RND_DIFF)) >>> 18;
        prod = (c * dq + longint'(RND_PROD)) >>> 16;
        r    = s - prod;
        res.sat = 1'b1;
        if (r > longint'(S_MAX))
            r = longint'(S_MAX);
        else if (r < longint'(S_MIN))
            r = longint'(S_MIN);
        else
            res.sat = 1'b0;
        res.value = r[SAMPLE_W-1:0];
        return res;
    endfunction

    // mostly register extremes, otherwise the nominal range or any 18-bit pattern
    function automatic logic signed [COURANT_W-1:0] pick_courant();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 7))
            0:       return C_ZERO;
            1:       return C_ONE;
            2:       return C_NEG_ONE;
            3:       return C_MAX;
            4:       return C_MIN;
            5, 6:    return COURANT_W'(int'($urandom_range(0, 131072)) - 65536);
            default: return raw[COURANT_W-1:0];
        endcase
    endfunction

    // smooth fields most of the time, then raw noise, then rail values
    function automatic sweep_in_t random_stencil();
        sweep_in_t   st;
        logic [31:0] v [5];
        logic [31:0] base;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        base = $urandom();
        for (int k = 0; k < 5; k++)
        begin
            if (kind < 6)
                v[k] = base + $urandom_range(0, 8191) - 32'd4096;
            else if (kind < 9)
                v[k] = $urandom();
            else
            begin
                case ($urandom_range(0, 3))
                    0:       v[k] = S_MAX;
                    1:       v[k] = S_MIN;
                    2:       v[k] = S_ZERO;
                    default: v[k] = $urandom();
                endcase
            end
        end
        st.func = 1'($urandom_range(0, 1));
        st.m2   = v[0];
        st.m1   = v[1];
        st.ctr  = v[2];
        st.p1   = v[3];
        st.p2   = v[4];
        return st;
    endfunction

    // one input transfer after a random gap (none while steady), expected result queued on acceptance
    task automatic send_stencil(input sweep_in_t st, input logic source, input sweep_out_t want);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, STALL_MAX);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= st.func;
        s_tdata  <= {st.p2, st.p1, st.ctr, st.m1, st.m2};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_cells.push_back(source == BY_HAND ? want : advect_stencil(st));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COURANT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_COURANT_X:  cur_cx = data;
            REG_COURANT_Y:  cur_cy = data;
            REG_SLOPE_MODE: cur_mode = data[0];
            default:        ;
        endcase
    endtask

    // registers change only with the pipeline empty
    task automatic load_registers(input logic signed [COURANT_W-1:0] cx,
                                  input logic signed [COURANT_W-1:0] cy,
                                  input logic [COURANT_W-1:0]        mode_word);
        logic [31:0] junk;
        junk = $urandom();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        write_reg(REG_COURANT_X, cx);
        write_reg(REG_COURANT_Y, cy);
        write_reg(REG_SLOPE_MODE, mode_word);
        // a write to the spare index must leave every register alone
        write_reg(REG_UNMAPPED, junk[COURANT_W-1:0]);
        cfg_we <= 1'b0;
    endtask

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%t: %s", $realtime, what);
    endtask

    // output side: random stall before each result transfer, none while steady
    initial
    begin
        int unsigned stall;
        m_tready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, STALL_MAX);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // result checker: every output transfer against the oldest owed value
    always @(posedge clk)
    begin
        sweep_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cells.size() == 0)
                report($sformatf("unexpected result value=%h sat=%b", m_tdata, m_tuser));
            else
            begin
                want = pending_cells.pop_front();
                if (m_tdata !== want.value || m_tuser !== want.sat)
                    report($sformatf("value exp=%h got=%h, sat exp=%b got=%b",
                                     want.value, m_tdata, want.sat, m_tuser));
            end
        end
    end

    // watchdog on cycles with no transfer and no register write
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("upwind_advection_cell_update: mismatch");
            $finish;
        end
    end

    // stimulus: directed rows, then phases of random stencils under fresh registers
    initial
    begin
        stim_row_t   row;
        logic [31:0] mode_raw;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_COURANT_X;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cur_cx    = C_ZERO;
        cur_cy    = C_ZERO;
        cur_mode  = SLOPE_CONST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first rows run on the reset values, registers reloaded when a row needs others
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.cx != cur_cx || row.cy != cur_cy || row.mode != cur_mode)
                load_registers(row.cx, row.cy, {{(COURANT_W-1){1'b0}}, row.mode});
            send_stencil(row.stencil, row.source, row.want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            mode_raw = $urandom();
            // slope mode alternates per phase, upper data bits random
            load_registers(pick_courant(), pick_courant(),
                           {mode_raw[COURANT_W-1:1], ph[0]});
            steady = (ph == 1) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_LEN; n++)
                send_stencil(random_stencil(), BY_MODEL, FROM_MODEL);
        end

        s_tvalid <= 1'b0;
        steady = 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending_cells.size() == 0)
            $display("upwind_advection_cell_update: match");
        else
            $display("upwind_advection_cell_update: mismatch");
        $finish;
    end

endmodule
